### sv/picture_cache_allocator_defines.svh
// Assertion macros used by the picture cache allocator RTL.
`ifndef PICTURE_CACHE_ALLOCATOR_DEFINES_SVH
`define PICTURE_CACHE_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define PCA_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCA_ASSERT(label, prop, msg) \
    `PCA_ASSERT_CLK(label, aclk, aresetn, prop, msg)
`else
`define PCA_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define PCA_ASSERT(label, prop, msg)
`endif

`endif

### sv/pca_pkg.sv
package pca_pkg;

    localparam int PCA_MAX_ENTRIES = 32;
    localparam int PCA_IDX_W = (PCA_MAX_ENTRIES > 1) ? $clog2(PCA_MAX_ENTRIES) : 1;
    localparam int PCA_CNT_W = $clog2(PCA_MAX_ENTRIES + 1);
    localparam int PCA_HDR_W = 5 + PCA_CNT_W;

    localparam logic [15:0] PCA_RST_BUFFER   = 16'd5120;
    localparam logic [15:0] PCA_RST_MAX_ITEM = 16'd1024;
    localparam logic [15:0] PCA_RST_CRITICAL = 16'd256;
    localparam logic [4:0]  PCA_RST_ENTRY    = 5'd10;

    localparam logic [1:0] REG_BUFFER   = 2'd0;
    localparam logic [1:0] REG_MAX_ITEM = 2'd1;
    localparam logic [1:0] REG_CRITICAL = 2'd2;
    localparam logic [1:0] REG_ENTRY    = 2'd3;

    localparam logic [1:0] ACT_BEGIN = 2'd0;
    localparam logic [1:0] ACT_OFFER = 2'd1;

    typedef enum logic [2:0] {
        STS_STORED    = 3'd0,
        STS_REJECTED  = 3'd1,
        STS_ABORTED   = 3'd2,
        STS_FOUND     = 3'd3,
        STS_NOT_FOUND = 3'd4,
        STS_NO_SPACE  = 3'd5,
        STS_BEGUN     = 3'd6
    } pca_status_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } pca_state_t;

    typedef struct packed {
        logic                 en;
        logic [PCA_IDX_W-1:0] addr;
        logic [15:0]          id;
        logic [15:0]          offset;
        logic [15:0]          length;
    } pca_wr_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] offset;
        logic [15:0] length;
    } pca_rd_t;

endpackage

### sv/pca_entry_store.sv
module pca_entry_store import pca_pkg::*; (
    input  logic                 aclk,
    input  pca_wr_t              wr,
    input  logic [PCA_IDX_W-1:0] rd_addr,
    input  logic [15:0]          key,
    output pca_rd_t              rd
);

    logic [47:0] mem [PCA_MAX_ENTRIES];
    logic [47:0] q_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= {wr.id, wr.offset, wr.length};
        end
        q_reg <= mem[rd_addr];
    end

    // match the registered entry against the searched id
    assign rd.hit    = (q_reg[47:32] == key);
    assign rd.offset = q_reg[31:16];
    assign rd.length = q_reg[15:0];

endmodule

### sv/picture_cache_allocator.sv
// Picture preload cache allocator.
// Input stream s_*: one item per transfer; s_tuser carries the action (begin set,
// offer picture, search id) and the entry valid flag, s_tdata the count, id and length.
// Result stream m_*: exactly one result per item; m_tuser is the status code,
// m_tdata the offset, length and number of stored pictures.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at the clock edge
// (0 buffer bytes, 1 max item bytes, 2 critical bytes, 3 header bytes per entry).
// Begin and offer go through S_EXEC to S_FINISH, which loads the output register.
// A search reads one stored entry per cycle from the entry memory and stops at the
// first hit; a miss reads every held entry before the not-found result is given.
// One item is in work at a time; s_tready returns with the cycle after the result
// is loaded into the output register. The next item can be taken while that result
// still waits for m_tready. A stalled receiver holds the result in the output
// register; a further finished result waits internally until it drains.
// Reset (aresetn low, synchronous) empties the table, closes any set and loads
// the default register values. Entry memory is not cleared; its contents beyond
// the held entries are never used as a result.
`include "picture_cache_allocator_defines.svh"

module picture_cache_allocator import pca_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // set_count[5:0], pic_id[21:6], data_len[45:22], zero pad
    input  logic [2:0]  s_tuser,   // action[1:0], entry_valid[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // data_offset[15:0], data_length[31:16],
                                   // stored_count[37:32], zero pad
    output logic [2:0]  m_tuser    // status[2:0]
);

    logic [15:0] buffer_reg, max_item_reg, critical_reg;
    logic [4:0]  entry_bytes_reg;

    pca_state_t           state_reg, state_next;
    logic [PCA_CNT_W-1:0] held_count_reg, held_count_next;
    logic [15:0]          next_free_reg, next_free_next;
    logic [15:0]          space_left_reg, space_left_next;
    logic [PCA_CNT_W-1:0] offers_left_reg, offers_left_next;
    logic                 set_open_reg, set_open_next;
    logic [PCA_CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    logic [1:0]  act_reg;
    logic [5:0]  cnt_reg;
    logic [15:0] id_reg;
    logic [23:0] len_reg;
    logic        valid_reg;

    pca_status_t res_status_reg, res_status_next;
    logic [15:0] res_off_reg, res_off_next;
    logic [15:0] res_len_reg, res_len_next;

    pca_status_t m_status_reg;
    logic [15:0] m_off_reg, m_len_reg;
    logic [5:0]  m_cnt_reg;

    logic                 s_accept, out_load;
    logic [PCA_CNT_W-1:0] sat_count, offers_dec;
    logic [PCA_HDR_W-1:0] header;
    logic [16:0]          rounded, nf_sum;
    pca_wr_t              wr;
    pca_rd_t              rd;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign sat_count = (32'(cnt_reg) > PCA_MAX_ENTRIES) ? PCA_CNT_W'(PCA_MAX_ENTRIES)
                                                        : PCA_CNT_W'(cnt_reg);
    assign header     = PCA_HDR_W'(entry_bytes_reg) * PCA_HDR_W'(sat_count);
    assign offers_dec = offers_left_reg - PCA_CNT_W'(1);
    assign rounded    = {1'b0, len_reg[15:0]} + 17'(len_reg[0]);
    assign nf_sum     = {1'b0, next_free_reg} + rounded;

    always_comb begin
        state_next       = state_reg;
        held_count_next  = held_count_reg;
        next_free_next   = next_free_reg;
        space_left_next  = space_left_reg;
        offers_left_next = offers_left_reg;
        set_open_next    = set_open_reg;
        scan_idx_next    = scan_idx_reg;
        rd_pend_next     = rd_pend_reg;
        res_status_next  = res_status_reg;
        res_off_next     = res_off_reg;
        res_len_next     = res_len_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        out_load         = 1'b0;
        wr.en            = 1'b0;
        wr.addr          = held_count_reg[PCA_IDX_W-1:0];
        wr.id            = id_reg;
        wr.offset        = next_free_reg;
        wr.length        = len_reg[15:0];

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next   = S_FINISH;
                res_off_next = '0;
                res_len_next = '0;
                if (act_reg == ACT_BEGIN) begin
                    held_count_next = '0;
                    if (32'(header) >= 32'(buffer_reg)) begin
                        set_open_next    = 1'b0;
                        offers_left_next = '0;
                        res_status_next  = STS_NO_SPACE;
                    end else begin
                        next_free_next   = 16'(header);
                        space_left_next  = buffer_reg - 16'(header);
                        offers_left_next = sat_count;
                        set_open_next    = (sat_count != '0);
                        res_status_next  = STS_BEGUN;
                    end
                end else if (act_reg == ACT_OFFER) begin
                    res_status_next = STS_REJECTED;
                    if (set_open_reg && offers_left_reg != '0) begin
                        offers_left_next = offers_dec;
                        if (offers_dec == '0) begin
                            set_open_next = 1'b0;
                        end
                        if (!valid_reg || len_reg > {8'd0, max_item_reg}) begin
                            res_status_next = STS_REJECTED;
                        end else if (len_reg > {8'd0, space_left_reg}) begin
                            // misfit: abort the set once space is down to critical
                            if (space_left_reg <= critical_reg) begin
                                offers_left_next = '0;
                                set_open_next    = 1'b0;
                                res_status_next  = STS_ABORTED;
                            end
                        end else if (held_count_reg < PCA_CNT_W'(PCA_MAX_ENTRIES)) begin
                            wr.en           = 1'b1;
                            held_count_next = held_count_reg + PCA_CNT_W'(1);
                            res_status_next = STS_STORED;
                            res_off_next    = next_free_reg;
                            res_len_next    = len_reg[15:0];
                            next_free_next  = nf_sum[16] ? 16'hFFFF : nf_sum[15:0];
                            space_left_next = (rounded > {1'b0, space_left_reg}) ? 16'd0
                                            : space_left_reg - rounded[15:0];
                        end
                    end
                end else begin
                    scan_idx_next = '0;
                    rd_pend_next  = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_pend_reg && rd.hit) begin
                    res_status_next = STS_FOUND;
                    res_off_next    = rd.offset;
                    res_len_next    = rd.length;
                    rd_pend_next    = 1'b0;
                    state_next      = S_FINISH;
                end else if (scan_idx_reg >= held_count_reg) begin
                    res_status_next = STS_NOT_FOUND;
                    rd_pend_next    = 1'b0;
                    state_next      = S_FINISH;
                end else begin
                    // advance: the read issued now returns next cycle
                    rd_pend_next  = 1'b1;
                    scan_idx_next = scan_idx_reg + PCA_CNT_W'(1);
                end
            end
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_reg      <= PCA_RST_BUFFER;
            max_item_reg    <= PCA_RST_MAX_ITEM;
            critical_reg    <= PCA_RST_CRITICAL;
            entry_bytes_reg <= PCA_RST_ENTRY;
            state_reg       <= S_IDLE;
            held_count_reg  <= '0;
            next_free_reg   <= '0;
            space_left_reg  <= '0;
            offers_left_reg <= '0;
            set_open_reg    <= 1'b0;
            scan_idx_reg    <= '0;
            rd_pend_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_BUFFER:   buffer_reg      <= cfg_wdata;
                    REG_MAX_ITEM: max_item_reg    <= cfg_wdata;
                    REG_CRITICAL: critical_reg    <= cfg_wdata;
                    REG_ENTRY:    entry_bytes_reg <= cfg_wdata[4:0];
                    default:      ;
                endcase
            end
            state_reg       <= state_next;
            held_count_reg  <= held_count_next;
            next_free_reg   <= next_free_next;
            space_left_reg  <= space_left_next;
            offers_left_reg <= offers_left_next;
            set_open_reg    <= set_open_next;
            scan_idx_reg    <= scan_idx_next;
            rd_pend_reg     <= rd_pend_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg   <= s_tuser[1:0];
            valid_reg <= s_tuser[2];
            cnt_reg   <= s_tdata[5:0];
            id_reg    <= s_tdata[21:6];
            len_reg   <= s_tdata[45:22];
        end
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_len_reg    <= res_len_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_off_reg    <= res_off_reg;
            m_len_reg    <= res_len_reg;
            m_cnt_reg    <= 6'(held_count_reg);
        end
    end

    pca_entry_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (scan_idx_reg[PCA_IDX_W-1:0]),
        .key     (id_reg),
        .rd      (rd)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, m_cnt_reg, m_len_reg, m_off_reg};

    `PCA_ASSERT(a_open_has_offers, set_open_reg |-> (offers_left_reg != '0), "open set without offers")
    `PCA_ASSERT(a_held_bound, held_count_reg <= PCA_CNT_W'(PCA_MAX_ENTRIES), "held count overflow")
    `PCA_ASSERT(a_scan_bound, (state_reg == S_SCAN) |-> (scan_idx_reg <= held_count_reg), "scan past held entries")
    `PCA_ASSERT(a_accept_exec, s_accept |=> (state_reg == S_EXEC), "accepted item not executed")

endmodule
